>>> hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked property that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> hdl/sts_pkg.sv
// Shared widths, codes and types for the sparse transpose scatter block.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`default_nettype none

package sts_pkg;

  localparam int COL_W  = 12;
  localparam int ROW_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 20;
  localparam int CUR_W  = ADDR_W + 1;

  // Element capacity; a cursor equal to it marks a full column.
  localparam logic [DATA_W-1:0] MAX_ELEMENTS = DATA_W'(1) << ADDR_W;
  localparam int NUM_COLUMNS = 1 << COL_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_SCATTER = 1'b1;

  // One classified operation between front and back.
  typedef struct packed {
    logic              is_load;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] value;
    logic [CUR_W-1:0]  load_cur;
  } op_t;

  // Queue occupancy seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> hdl/sts_in_if.sv
// Input channel of the scatter block: command, row, column and value.
// Depends on sts_pkg for the field widths.
`default_nettype none

interface sts_in_if import sts_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  column_index;
  logic [DATA_W-1:0] value;

  modport source (output valid, cmd, row_index, column_index, value, input ready);
  modport sink   (input valid, cmd, row_index, column_index, value, output ready);
endinterface

`default_nettype wire

>>> hdl/sts_out_if.sv
// Result channel of the scatter block: slot address, row, value, overflow.
// Depends on sts_pkg for the field widths.
`default_nettype none

interface sts_out_if import sts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [ROW_W-1:0]  out_row_index;
  logic [DATA_W-1:0] out_value;
  logic              overflow;

  modport source (output valid, write_address, out_row_index, out_value, overflow,
                  input ready);
  modport sink   (input valid, write_address, out_row_index, out_value, overflow,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/sparse_transpose_scatter.sv
// Scatter phase of a sparse matrix transpose: per-column write cursors.
// Top level; depends on sts_pkg, sts_in_if, sts_out_if, sts_front, sts_queue, sts_back.
//
// Usage:
//   in_ch  (sink)  : cmd 0 loads column_index's cursor with value (clamped to
//                    capacity), no result; cmd 1 scatters one element.
//   out_ch (source): one transfer per scatter item, in order: slot address,
//                    row index, value, overflow (address 0 when overflowing).
// Path: a scatter item passes the queue, the back stage and the result register,
//   in that order, before its result shows on out_ch.
// Throughput: one item per cycle while out_ch is ready; the cursor memory has one read
//   and one write port, and a cursor written on the edge that a read samples
//   is forwarded, so repeated hits on one column do not slow the stream.
// Reset: queue, back stage and result register empty. The cursor memory is
//   not cleared; a column's cursor is undefined until a load item sets it.
// Stall: a result waiting on out_ch holds; the back stage and then the
//   four-entry queue fill, after which in_ch.ready drops.
`default_nettype none

module sparse_transpose_scatter import sts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch
);

  q_stat_t q_stat;
  logic    push, pop;
  op_t     push_op, pop_op;

  sts_front u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  sts_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  sts_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .pop_op (pop_op),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/sts_front.sv
// Front end: accepts input transfers, classifies them and saturates load offsets.
// Depends on sts_pkg and sts_in_if; feeds sts_queue.
`default_nettype none

module sts_front import sts_pkg::*; (
  sts_in_if.sink  in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output op_t     push_op
);

  logic sat;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Clamp a start offset beyond capacity so the column reads as full later.
  assign sat = in_ch.value > MAX_ELEMENTS;

  always_comb begin
    push_op.is_load  = (in_ch.cmd == CMD_LOAD);
    push_op.col      = in_ch.column_index;
    push_op.row      = in_ch.row_index;
    push_op.value    = in_ch.value;
    push_op.load_cur = sat ? MAX_ELEMENTS[CUR_W-1:0] : in_ch.value[CUR_W-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/sts_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on sts_pkg.
`default_nettype none

module sts_queue import sts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     pop_op,
  output q_stat_t q_stat
);

  op_t               slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_op       = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + (QPTR_W+1)'(1);
      2'b01:   count_nxt = count_r - (QPTR_W+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_op;
  end

endmodule

`default_nettype wire

>>> hdl/sts_back.sv
// Back end: cursor memory read-modify-write with forwarding, and the result register.
// Depends on sts_pkg and sts_out_if; drains sts_queue.
`default_nettype none

module sts_back import sts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  op_t     pop_op,
  output logic    pop,
  sts_out_if.source out_ch
);

  logic [CUR_W-1:0] cursor_mem [NUM_COLUMNS];

  logic              b_vld_r, b_vld_nxt;
  op_t               b_op_r;
  logic [CUR_W-1:0]  rd_cur_r;
  logic              fwd_hit_r;
  logic [CUR_W-1:0]  fwd_cur_r;

  logic              out_vld_r, out_vld_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_ovf_r;

  logic              out_free, b_fire, b_adv, col_full, we;
  logic [CUR_W-1:0]  cur, wr_cur;

  assign out_free = !out_vld_r || out_ch.ready;
  assign b_fire   = b_vld_r && (b_op_r.is_load || out_free);
  assign b_adv    = !b_vld_r || b_fire;
  assign pop      = b_adv && !q_stat.empty;

  // Take the cursor written on the edge the read was sampled, if same column.
  assign cur      = fwd_hit_r ? fwd_cur_r : rd_cur_r;
  assign col_full = cur[CUR_W-1];
  assign we       = b_fire && (b_op_r.is_load || !col_full);
  assign wr_cur   = b_op_r.is_load ? b_op_r.load_cur : cur + CUR_W'(1);

  assign b_vld_nxt   = pop || (b_vld_r && !b_fire);
  assign out_vld_nxt = (b_fire && !b_op_r.is_load) || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (we) cursor_mem[b_op_r.col] <= wr_cur;
  end

  always_ff @(posedge clk) begin
    if (pop) rd_cur_r <= cursor_mem[pop_op.col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (pop) fwd_hit_r <= we && (b_op_r.col == pop_op.col);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op_r    <= pop_op;
      fwd_cur_r <= wr_cur;
    end
    if (b_fire && !b_op_r.is_load) begin
      out_addr_r  <= col_full ? '0 : cur[ADDR_W-1:0];
      out_row_r   <= b_op_r.row;
      out_value_r <= b_op_r.value;
      out_ovf_r   <= col_full;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.write_address = out_addr_r;
  assign out_ch.out_row_index = out_row_r;
  assign out_ch.out_value     = out_value_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

`default_nettype wire

>>> hdl/sts_checker.sv
// Port-level checks of the scatter block, attached to the top level by bind.
// Depends on sts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sts_checker import sts_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] write_address,
  input wire logic [ROW_W-1:0]  out_row_index,
  input wire logic [DATA_W-1:0] out_value,
  input wire logic              overflow
);

  // A stalled result holds until transferred.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(write_address) && $stable(out_row_index) && $stable(out_value) && $stable(overflow))

  // An overflowing result carries slot address zero.
  `ASSERT_CLK(a_ovf_addr, clk, rst_n, out_valid && overflow |-> write_address == '0)

  // Reset empties the result register.
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind sparse_transpose_scatter sts_checker u_sts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .write_address (out_ch.write_address),
  .out_row_index (out_ch.out_row_index),
  .out_value     (out_ch.out_value),
  .overflow      (out_ch.overflow)
);

`default_nettype wire
